### hdl/assert_macros.svh
// Assertion macros shared by the navigation controller RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define BTNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define BTNC_ASSERT_NEVER(lbl, cond, msg) \
  `BTNC_ASSERT(lbl, !(cond), msg)

`endif

### hdl/btnc_pkg.sv
// Package for the bump-and-turn navigation controller: constants, codes,
// and the input and result transfer types. Depends on nothing.
`default_nettype none

package btnc_pkg;

  // Decision history depth and derived widths.
  localparam int unsigned HistDepth     = 10;
  localparam int unsigned HistIdxW      = $clog2(HistDepth);
  localparam int unsigned HistCntW      = $clog2(HistDepth + 1);
  localparam int unsigned OneSidedCount = 8;
  localparam int unsigned QuickHitLimit = 3;

  // Motor setting that the start kick leaves behind.
  localparam logic [7:0] KickLeftDuty  = 8'd230;
  localparam logic [7:0] KickRightDuty = 8'd255;

  // Command codes.
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Drive codes.
  localparam logic [2:0] DRIVE_STOP  = 3'd0;
  localparam logic [2:0] DRIVE_FWD   = 3'd1;
  localparam logic [2:0] DRIVE_REV   = 3'd2;
  localparam logic [2:0] DRIVE_LEFT  = 3'd3;
  localparam logic [2:0] DRIVE_RIGHT = 3'd4;

  // Phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_REV  = 2'd2;
  localparam logic [1:0] PH_TURN = 2'd3;

  // History entry codes.
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRONT_THR   = 3'd0;
  localparam logic [2:0] CFG_FLOOR_THR   = 3'd1;
  localparam logic [2:0] CFG_REVERSE_MS  = 3'd2;
  localparam logic [2:0] CFG_HIT_WINDOW  = 3'd3;
  localparam logic [2:0] CFG_SIDE_MARGIN = 3'd4;
  localparam logic [2:0] CFG_FWD_LEFT    = 3'd5;
  localparam logic [2:0] CFG_FWD_RIGHT   = 3'd6;
  localparam logic [2:0] CFG_TURN_SPEED  = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Shared adder operation.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // One control tick.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [8:0]  front_cm;
    logic [8:0]  left_cm;
    logic [8:0]  right_cm;
    logic [9:0]  floor_level;
    logic [1:0]  mode;
    logic        random_side;
    logic [9:0]  random_short_ms;
    logic [10:0] random_long_ms;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [2:0] drive;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic       kick_start;
    logic       brake_pulse;
    logic [1:0] phase;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/bump_turn_navigation_controller_unit.sv
// Bump-and-turn navigation controller: input latch, sequencer, state and
// decision history, result register. Depends on btnc_pkg, btnc_alu, and
// assert_macros.svh.
//
// Each accepted tick is worked through by a small sequencer that drives one
// shared 32-bit adder, one compare or sum per cycle. An idle or stop tick goes
// straight from the command step to the final step; a reverse that ends scans
// the decision history one entry per cycle and runs both side comparisons
// through the adder. The final step also waits for as long as an earlier
// result is held in the output register by a stalled consumer. in_stall_o
// stays high from the input transfer until the block is ready again. The
// result register lets the next tick be taken while a result still waits.
`default_nettype none

`include "assert_macros.svh"

module bump_turn_navigation_controller_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic              [btnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic              [btnc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire btnc_pkg::in_item_t                    in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output btnc_pkg::out_item_t                        out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_FRONT,
    ST_FLOOR,
    ST_HITGAP,
    ST_HITWIN,
    ST_ELAPSED,
    ST_TIMEOUT,
    ST_COUNT,
    ST_RSUM,
    ST_LGT,
    ST_LSUM,
    ST_RGT,
    ST_DONE
  } seq_state_e;

  // Configuration registers.
  logic [8:0]  front_thr_q;
  logic [9:0]  floor_thr_q;
  logic [15:0] reverse_ms_q;
  logic [15:0] hit_window_q;
  logic [7:0]  side_margin_q;
  logic [7:0]  fwd_left_q;
  logic [7:0]  fwd_right_q;
  logic [7:0]  turn_speed_q;

  // Controller state.
  seq_state_e                       st_q;
  btnc_pkg::in_item_t               item_q;
  btnc_pkg::out_item_t              res_q;
  btnc_pkg::out_item_t              out_q;
  logic                             out_valid_q;
  logic [1:0]                       phase_q;
  logic [31:0]                      mstart_q;
  logic [31:0]                      last_hit_q;
  logic [3:0]                       quick_hits_q;
  logic [1:0]                       hist_q [btnc_pkg::HistDepth];
  logic [btnc_pkg::HistIdxW-1:0]    hist_pos_q;
  logic                             turn_left_q;
  logic [10:0]                      turn_dur_q;

  // Sequencer work registers.
  logic                             flag_q;
  logic [31:0]                      diff_q;
  logic [btnc_pkg::HistIdxW-1:0]    idx_q;
  logic [btnc_pkg::HistCntW-1:0]    nl_q;
  logic [btnc_pkg::HistCntW-1:0]    nr_q;
  logic                             lgt_q;

  // Shared adder.
  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  btnc_pkg::alu_op_e alu_op;
  logic [31:0]       alu_res;
  logic              alu_borrow;

  btnc_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .op_i     (alu_op),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Operand selection for the current sequencer step.
  always_comb begin
    alu_a  = 32'd0;
    alu_b  = 32'd0;
    alu_op = btnc_pkg::ALU_SUB;
    case (st_q)
      ST_FRONT: begin
        alu_a = 32'(item_q.front_cm);
        alu_b = 32'(front_thr_q);
      end
      ST_FLOOR: begin
        alu_a = 32'(item_q.floor_level);
        alu_b = 32'(floor_thr_q);
      end
      ST_HITGAP: begin
        alu_a = item_q.now_ms;
        alu_b = last_hit_q;
      end
      ST_HITWIN: begin
        alu_a = diff_q;
        alu_b = 32'(hit_window_q);
      end
      ST_ELAPSED: begin
        alu_a = item_q.now_ms;
        alu_b = mstart_q;
      end
      ST_TIMEOUT: begin
        alu_a = (phase_q == btnc_pkg::PH_REV) ? 32'(reverse_ms_q) : 32'(turn_dur_q);
        alu_b = diff_q;
      end
      ST_RSUM: begin
        alu_a  = 32'(item_q.right_cm);
        alu_b  = 32'(side_margin_q);
        alu_op = btnc_pkg::ALU_ADD;
      end
      ST_LGT: begin
        alu_a = diff_q;
        alu_b = 32'(item_q.left_cm);
      end
      ST_LSUM: begin
        alu_a  = 32'(item_q.left_cm);
        alu_b  = 32'(side_margin_q);
        alu_op = btnc_pkg::ALU_ADD;
      end
      ST_RGT: begin
        alu_a = diff_q;
        alu_b = 32'(item_q.right_cm);
      end
      default: begin
        alu_op = btnc_pkg::ALU_SUB;
      end
    endcase
  end

  // Effective phase after the command of the latched tick.
  logic [1:0] cmd_phase;
  always_comb begin
    case (item_q.mode)
      btnc_pkg::MODE_START: cmd_phase = btnc_pkg::PH_FWD;
      btnc_pkg::MODE_STOP:  cmd_phase = btnc_pkg::PH_IDLE;
      default:              cmd_phase = phase_q;
    endcase
  end

  // Turn decision at the end of a reverse.
  logic       escape;
  logic       new_left;
  logic [1:0] new_side;
  assign escape = (quick_hits_q > 4'(btnc_pkg::QuickHitLimit)) ||
                  (nl_q >= btnc_pkg::HistCntW'(btnc_pkg::OneSidedCount)) ||
                  (nr_q >= btnc_pkg::HistCntW'(btnc_pkg::OneSidedCount));
  always_comb begin
    if (escape || !(lgt_q || alu_borrow)) begin
      new_left = item_q.random_side;
    end else begin
      new_left = lgt_q;
    end
  end
  assign new_side = new_left ? btnc_pkg::SIDE_LEFT : btnc_pkg::SIDE_RIGHT;

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (st_q == ST_DONE) && out_free;

  // Sequencer, controller state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_thr_q   <= 9'd30;
      floor_thr_q   <= 10'd300;
      reverse_ms_q  <= 16'd400;
      hit_window_q  <= 16'd5000;
      side_margin_q <= 8'd10;
      fwd_left_q    <= 8'd255;
      fwd_right_q   <= 8'd255;
      turn_speed_q  <= 8'd255;
      st_q          <= ST_IDLE;
      item_q        <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      phase_q       <= btnc_pkg::PH_IDLE;
      mstart_q      <= 32'd0;
      last_hit_q    <= 32'd0;
      quick_hits_q  <= 4'd0;
      for (int i = 0; i < btnc_pkg::HistDepth; i++) begin
        hist_q[i] <= btnc_pkg::SIDE_NONE;
      end
      hist_pos_q    <= '0;
      turn_left_q   <= 1'b0;
      turn_dur_q    <= 11'd600;
      flag_q        <= 1'b0;
      diff_q        <= 32'd0;
      idx_q         <= '0;
      nl_q          <= '0;
      nr_q          <= '0;
      lgt_q         <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          btnc_pkg::CFG_FRONT_THR:   front_thr_q   <= cfg_data_i[8:0];
          btnc_pkg::CFG_FLOOR_THR:   floor_thr_q   <= cfg_data_i[9:0];
          btnc_pkg::CFG_REVERSE_MS:  reverse_ms_q  <= cfg_data_i;
          btnc_pkg::CFG_HIT_WINDOW:  hit_window_q  <= cfg_data_i;
          btnc_pkg::CFG_SIDE_MARGIN: side_margin_q <= cfg_data_i[7:0];
          btnc_pkg::CFG_FWD_LEFT:    fwd_left_q    <= cfg_data_i[7:0];
          btnc_pkg::CFG_FWD_RIGHT:   fwd_right_q   <= cfg_data_i[7:0];
          btnc_pkg::CFG_TURN_SPEED:  turn_speed_q  <= cfg_data_i[7:0];
          default:                   turn_speed_q  <= turn_speed_q;
        endcase
      end

      // The final step loads a result; the consumer takes the waiting one.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            st_q   <= ST_CMD;
          end
        end

        // Apply the command and set the motor output of the phase.
        ST_CMD: begin
          phase_q           <= cmd_phase;
          flag_q            <= 1'b0;
          res_q.kick_start  <= (item_q.mode == btnc_pkg::MODE_START);
          res_q.brake_pulse <= (item_q.mode == btnc_pkg::MODE_STOP);
          case (cmd_phase)
            btnc_pkg::PH_FWD: begin
              res_q.drive      <= btnc_pkg::DRIVE_FWD;
              res_q.left_duty  <= fwd_left_q;
              res_q.right_duty <= fwd_right_q;
              st_q             <= ST_FRONT;
            end
            btnc_pkg::PH_REV: begin
              res_q.drive      <= btnc_pkg::DRIVE_REV;
              res_q.left_duty  <= turn_speed_q;
              res_q.right_duty <= turn_speed_q;
              st_q             <= ST_ELAPSED;
            end
            btnc_pkg::PH_TURN: begin
              res_q.drive      <= turn_left_q ? btnc_pkg::DRIVE_LEFT : btnc_pkg::DRIVE_RIGHT;
              res_q.left_duty  <= turn_speed_q;
              res_q.right_duty <= turn_speed_q;
              st_q             <= ST_ELAPSED;
            end
            default: begin
              res_q.drive      <= btnc_pkg::DRIVE_STOP;
              res_q.left_duty  <= 8'd0;
              res_q.right_duty <= 8'd0;
              st_q             <= ST_DONE;
            end
          endcase
        end

        // Obstacle checks: front distance, then floor drop.
        ST_FRONT: begin
          flag_q <= alu_borrow;
          st_q   <= ST_FLOOR;
        end

        ST_FLOOR: begin
          if (flag_q || alu_borrow) begin
            phase_q  <= btnc_pkg::PH_REV;
            mstart_q <= item_q.now_ms;
            st_q     <= ST_HITGAP;
          end else begin
            st_q <= ST_DONE;
          end
        end

        // Quick repeated hit tracking.
        ST_HITGAP: begin
          diff_q <= alu_res;
          st_q   <= ST_HITWIN;
        end

        ST_HITWIN: begin
          if (alu_borrow) begin
            if (quick_hits_q != 4'hF) begin
              quick_hits_q <= quick_hits_q + 4'd1;
            end
          end else begin
            quick_hits_q <= 4'd0;
          end
          last_hit_q <= item_q.now_ms;
          st_q       <= ST_DONE;
        end

        // Maneuver timer: elapsed time, then compare with its length.
        ST_ELAPSED: begin
          diff_q <= alu_res;
          st_q   <= ST_TIMEOUT;
        end

        ST_TIMEOUT: begin
          if (!alu_borrow) begin
            st_q <= ST_DONE;
          end else if (phase_q == btnc_pkg::PH_TURN) begin
            phase_q          <= btnc_pkg::PH_FWD;
            res_q.kick_start <= 1'b1;
            res_q.drive      <= btnc_pkg::DRIVE_FWD;
            res_q.left_duty  <= btnc_pkg::KickLeftDuty;
            res_q.right_duty <= btnc_pkg::KickRightDuty;
            st_q             <= ST_DONE;
          end else begin
            phase_q  <= btnc_pkg::PH_TURN;
            mstart_q <= item_q.now_ms;
            idx_q    <= '0;
            nl_q     <= '0;
            nr_q     <= '0;
            st_q     <= ST_COUNT;
          end
        end

        // Count left and right decisions, one history entry per cycle.
        ST_COUNT: begin
          if (hist_q[idx_q] == btnc_pkg::SIDE_LEFT) begin
            nl_q <= nl_q + btnc_pkg::HistCntW'(1);
          end
          if (hist_q[idx_q] == btnc_pkg::SIDE_RIGHT) begin
            nr_q <= nr_q + btnc_pkg::HistCntW'(1);
          end
          if (idx_q == btnc_pkg::HistIdxW'(btnc_pkg::HistDepth - 1)) begin
            st_q <= ST_RSUM;
          end else begin
            idx_q <= idx_q + btnc_pkg::HistIdxW'(1);
          end
        end

        // Side comparisons through the adder.
        ST_RSUM: begin
          diff_q <= alu_res;
          st_q   <= ST_LGT;
        end

        ST_LGT: begin
          lgt_q <= alu_borrow;
          st_q  <= ST_LSUM;
        end

        ST_LSUM: begin
          diff_q <= alu_res;
          st_q   <= ST_RGT;
        end

        // Choose side and duration, then record the decision.
        ST_RGT: begin
          turn_left_q <= new_left;
          if (escape) begin
            turn_dur_q   <= item_q.random_long_ms;
            quick_hits_q <= 4'd0;
          end else begin
            turn_dur_q <= {1'b0, item_q.random_short_ms};
          end
          for (int i = 0; i < btnc_pkg::HistDepth; i++) begin
            if (btnc_pkg::HistIdxW'(i) == hist_pos_q) begin
              hist_q[i] <= new_side;
            end else if (escape) begin
              hist_q[i] <= btnc_pkg::SIDE_NONE;
            end
          end
          if (hist_pos_q == btnc_pkg::HistIdxW'(btnc_pkg::HistDepth - 1)) begin
            hist_pos_q <= '0;
          end else begin
            hist_pos_q <= hist_pos_q + btnc_pkg::HistIdxW'(1);
          end
          st_q <= ST_DONE;
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (out_free) begin
            out_q <= btnc_pkg::out_item_t'{drive:       res_q.drive,
                                           left_duty:   res_q.left_duty,
                                           right_duty:  res_q.right_duty,
                                           kick_start:  res_q.kick_start,
                                           brake_pulse: res_q.brake_pulse,
                                           phase:       phase_q};
            st_q  <= ST_IDLE;
          end
        end

        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only comes from the final sequencer step.
  `BTNC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(st_q == ST_DONE), "result loaded outside final step")
  // The reported phase is the controller phase after the tick.
  `BTNC_ASSERT(a_phase_matches, $rose(out_valid_q) |-> (out_q.phase == phase_q), "result phase mismatch")
  // Quick hit count only steps up by one or clears.
  `BTNC_ASSERT(a_hits_step, (quick_hits_q != $past(quick_hits_q)) |-> ((quick_hits_q == 4'd0) || (quick_hits_q == $past(quick_hits_q) + 4'd1)), "quick hit count jumped")
  // History write position always stays inside the history.
  `BTNC_ASSERT(a_pos_range, 32'(hist_pos_q) < btnc_pkg::HistDepth, "history position out of range")
  // A tick never both kicks and brakes.
  `BTNC_ASSERT_NEVER(a_kick_brake, out_valid_q && out_q.kick_start && out_q.brake_pulse, "kick and brake together")

endmodule

`default_nettype wire

### hdl/btnc_alu.sv
// Shared 32-bit add/subtract unit of the navigation controller.
// Depends on btnc_pkg for the operation code.
`default_nettype none

module btnc_alu (
  input  wire logic             [31:0] a_i,
  input  wire logic             [31:0] b_i,
  input  wire btnc_pkg::alu_op_e       op_i,
  output logic                  [31:0] res_o,
  output logic                         borrow_o
);

  logic        sub;
  logic [31:0] b_opnd;
  logic [32:0] sum;

  // One adder; subtraction adds the inverted operand plus one.
  assign sub    = (op_i == btnc_pkg::ALU_SUB);
  assign b_opnd = sub ? ~b_i : b_i;
  assign sum    = {1'b0, a_i} + {1'b0, b_opnd} + {32'd0, sub};

  assign res_o    = sum[31:0];
  // For a subtraction a missing carry means a is below b.
  assign borrow_o = sub & ~sum[32];

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the bump-and-turn navigation controller.
// Depends on btnc_pkg and bump_turn_navigation_controller_unit; it drives control
// ticks, predicts every motor command and compares each result transfer.
`timescale 1ns / 100ps

module tb;
  import btnc_pkg::*;

  // Command codes that the package leaves unnamed.
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseTicks  = 210;
  localparam int unsigned ReportLimit = 10;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Idle rates in percent for the two sides.
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 86;

  // Predicted controller settings, at their reset values.
  logic [8:0]  front_thr = 9'd30;
  logic [9:0]  floor_thr = 10'd300;
  logic [15:0] reverse_ms = 16'd400;
  logic [15:0] hit_window = 16'd5000;
  logic [7:0]  side_margin = 8'd10;
  logic [7:0]  fwd_left = 8'd255;
  logic [7:0]  fwd_right = 8'd255;
  logic [7:0]  turn_duty = 8'd255;

  // Predicted navigation state, at its reset values.
  logic [1:0]  nav_phase = PH_IDLE;
  logic [31:0] man_start = '0;
  logic [31:0] last_hit = '0;
  logic [3:0]  hit_count = '0;
  logic [1:0]  turn_hist [HistDepth] = '{default: SIDE_NONE};
  logic [3:0]  hist_pos = '0;
  logic        go_left = 1'b0;
  logic [10:0] turn_len = 11'd600;

  // Scenario state for the random ticks.
  logic [31:0] sim_ms = '0;
  logic [1:0]  side_lean = SIDE_NONE;
  logic        fast_pace = 1'b0;

  logic [15:0] setting_vals [8];
  out_item_t   pending_cmds [$];
  out_item_t   want_cmd;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  int unsigned result_count = 0;

  bump_turn_navigation_controller_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk_tick(input logic [31:0] now, input logic [8:0] front,
                                       input logic [8:0] lft, input logic [8:0] rgt,
                                       input logic [9:0] floor_lv, input logic [1:0] cmd,
                                       input logic side, input logic [9:0] short_ms,
                                       input logic [10:0] long_ms);
    in_item_t t;
    t.now_ms          = now;
    t.front_cm        = front;
    t.left_cm         = lft;
    t.right_cm        = rgt;
    t.floor_level     = floor_lv;
    t.mode            = cmd;
    t.random_side     = side;
    t.random_short_ms = short_ms;
    t.random_long_ms  = long_ms;
    return t;
  endfunction

  function automatic out_item_t mk_cmd(input logic [2:0] drive, input logic [7:0] ld,
                                       input logic [7:0] rd, input logic kick,
                                       input logic brake, input logic [1:0] ph);
    out_item_t r;
    r.drive       = drive;
    r.left_duty   = ld;
    r.right_duty  = rd;
    r.kick_start  = kick;
    r.brake_pulse = brake;
    r.phase       = ph;
    return r;
  endfunction

  // Works out the motor command for one tick and moves the predicted state on.
  function automatic out_item_t next_motor_cmd(input in_item_t t);
    out_item_t   r;
    logic [31:0] elapsed;
    int unsigned n_left;
    int unsigned n_right;
    int unsigned lft;
    int unsigned rgt;
    r = '0;
    lft = t.left_cm;
    rgt = t.right_cm;
    elapsed = t.now_ms - man_start;

    // Start and stop commands are honored in every phase.
    if (t.mode == MODE_START) begin
      r = mk_cmd(DRIVE_FWD, KickLeftDuty, KickRightDuty, 1'b1, 1'b0, PH_FWD);
      nav_phase = PH_FWD;
    end else if (t.mode == MODE_STOP) begin
      r.brake_pulse = 1'b1;
      nav_phase = PH_IDLE;
    end

    case (nav_phase)
      PH_FWD: begin
        r.drive = DRIVE_FWD;
        r.left_duty = fwd_left;
        r.right_duty = fwd_right;
        if (t.front_cm < front_thr || t.floor_level < floor_thr) begin
          nav_phase = PH_REV;
          man_start = t.now_ms;
          elapsed = t.now_ms - last_hit;
          if (elapsed < {16'd0, hit_window}) begin
            if (hit_count != 4'd15) hit_count = hit_count + 4'd1;
          end else begin
            hit_count = '0;
          end
          last_hit = t.now_ms;
        end
      end
      PH_REV: begin
        r.drive = DRIVE_REV;
        r.left_duty = turn_duty;
        r.right_duty = turn_duty;
        if (elapsed > {16'd0, reverse_ms}) begin
          nav_phase = PH_TURN;
          man_start = t.now_ms;
          n_left = 0;
          n_right = 0;
          foreach (turn_hist[i]) begin
            if (turn_hist[i] == SIDE_LEFT) n_left++;
            if (turn_hist[i] == SIDE_RIGHT) n_right++;
          end
          // Too many quick hits or a lopsided history force a long escape turn.
          if (hit_count > QuickHitLimit || n_left >= OneSidedCount ||
              n_right >= OneSidedCount) begin
            go_left = t.random_side;
            turn_len = t.random_long_ms;
            hit_count = '0;
            turn_hist = '{default: SIDE_NONE};
          end else begin
            if (lft > rgt + side_margin) go_left = 1'b1;
            else if (rgt > lft + side_margin) go_left = 1'b0;
            else go_left = t.random_side;
            turn_len = {1'b0, t.random_short_ms};
          end
          if (hist_pos >= HistDepth) hist_pos = '0;
          turn_hist[hist_pos] = go_left ? SIDE_LEFT : SIDE_RIGHT;
          hist_pos = hist_pos + 4'd1;
          if (hist_pos >= HistDepth) hist_pos = '0;
        end
      end
      PH_TURN: begin
        r.drive = go_left ? DRIVE_LEFT : DRIVE_RIGHT;
        r.left_duty = turn_duty;
        r.right_duty = turn_duty;
        if (elapsed > {21'd0, turn_len}) begin
          r = mk_cmd(DRIVE_FWD, KickLeftDuty, KickRightDuty, 1'b1, 1'b0, PH_FWD);
          nav_phase = PH_FWD;
        end
      end
      default: ;
    endcase
    r.phase = nav_phase;
    return r;
  endfunction

  // Random tick: mostly plausible sensor traffic with a running clock, some noise.
  function automatic in_item_t random_tick();
    in_item_t    t;
    int unsigned roll;
    if ($urandom_range(79) == 0) begin
      side_lean = 2'($urandom_range(2));
      fast_pace = 1'($urandom_range(1));
    end
    roll = $urandom_range(99);
    if (roll < 6) begin
      t = mk_tick($urandom(), 9'($urandom_range(511)), 9'($urandom_range(511)),
                  9'($urandom_range(511)), 10'($urandom_range(1023)),
                  2'($urandom_range(3)), 1'($urandom_range(1)),
                  10'($urandom_range(1023)), 11'($urandom_range(2047)));
      sim_ms = t.now_ms;
      return t;
    end
    if (fast_pace) sim_ms += $urandom_range(120);
    else if (roll < 80) sim_ms += $urandom_range(1, 300);
    else if (roll < 98) sim_ms += $urandom_range(300, 3000);
    else sim_ms += $urandom_range(70000);
    t.now_ms = sim_ms;

    roll = $urandom_range(99);
    if (nav_phase == PH_IDLE) t.mode = (roll < 50) ? MODE_START : CMD_NONE;
    else if (roll < 2) t.mode = MODE_START;
    else if (roll < 4) t.mode = MODE_STOP;
    else if (roll < 5) t.mode = CMD_IGNORED;
    else t.mode = CMD_NONE;

    roll = $urandom_range(99);
    if (roll < 25) t.front_cm = 9'($urandom_range(60));
    else if (roll < 28) t.front_cm = 9'($urandom_range(401, 511));
    else t.front_cm = 9'($urandom_range(60, 400));
    t.floor_level = ($urandom_range(9) == 0) ? 10'($urandom_range(350))
                                             : 10'($urandom_range(300, 1023));

    // The side distances follow the current lean so that histories can fill up.
    if (side_lean == SIDE_LEFT) begin
      t.left_cm  = 9'($urandom_range(200, 400));
      t.right_cm = 9'($urandom_range(150));
    end else if (side_lean == SIDE_RIGHT) begin
      t.left_cm  = 9'($urandom_range(150));
      t.right_cm = 9'($urandom_range(200, 400));
    end else begin
      t.left_cm  = 9'($urandom_range(($urandom_range(29) == 0) ? 511 : 400));
      t.right_cm = 9'($urandom_range(($urandom_range(29) == 0) ? 511 : 400));
    end
    t.random_side = 1'($urandom_range(1));
    t.random_short_ms = ($urandom_range(19) == 0) ? 10'($urandom_range(1023))
                                                  : 10'($urandom_range(400, 899));
    t.random_long_ms = ($urandom_range(19) == 0) ? 11'($urandom_range(2047))
                                                 : 11'($urandom_range(1200, 1799));
    return t;
  endfunction

  function automatic void flag_bad(input string what);
    bad_results++;
    if (bad_results <= ReportLimit) $display("ERROR: %s", what);
  endfunction

  // Offers one tick after a random gap and records its command on transfer.
  // Called and returns at a falling edge.
  task automatic send_tick(input in_item_t t, input bit typed, input out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    pending_cmds.push_back(typed ? want : next_motor_cmd(t));
    if (typed) void'(next_motor_cmd(t));
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted command has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_cmds.size() != 0);
  endtask

  // Writes all eight settings from setting_vals, one per cycle.
  task automatic load_settings();
    logic [2:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= setting_vals[i];
      case (idx)
        CFG_FRONT_THR:   front_thr   = setting_vals[i][8:0];
        CFG_FLOOR_THR:   floor_thr   = setting_vals[i][9:0];
        CFG_REVERSE_MS:  reverse_ms  = setting_vals[i];
        CFG_HIT_WINDOW:  hit_window  = setting_vals[i];
        CFG_SIDE_MARGIN: side_margin = setting_vals[i][7:0];
        CFG_FWD_LEFT:    fwd_left    = setting_vals[i][7:0];
        CFG_FWD_RIGHT:   fwd_right   = setting_vals[i][7:0];
        CFG_TURN_SPEED:  turn_duty   = setting_vals[i][7:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver stalls at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result transfers are compared with the oldest predicted command.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_cmds.size() == 0) begin
        flag_bad($sformatf("result %0d with no tick waiting: drive %0d phase %0d",
                           result_count, out_data.drive, out_data.phase));
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (out_data.drive !== want_cmd.drive ||
            out_data.left_duty !== want_cmd.left_duty ||
            out_data.right_duty !== want_cmd.right_duty ||
            out_data.kick_start !== want_cmd.kick_start ||
            out_data.brake_pulse !== want_cmd.brake_pulse ||
            out_data.phase !== want_cmd.phase) begin
          flag_bad($sformatf({"result %0d: expected drive %0d duty %0d/%0d kick %0b ",
                              "brake %0b phase %0d, got drive %0d duty %0d/%0d kick %0b ",
                              "brake %0b phase %0d"}, result_count,
                             want_cmd.drive, want_cmd.left_duty, want_cmd.right_duty,
                             want_cmd.kick_start, want_cmd.brake_pulse, want_cmd.phase,
                             out_data.drive, out_data.left_duty, out_data.right_duty,
                             out_data.kick_start, out_data.brake_pulse, out_data.phase));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: run did not finish within %0d cycles", CycleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk under the reset settings: commands, threshold edges, timer
    // edges, side choice, quick-hit escape, out-of-range random inputs, time wrap.
    dir_rows.push_back(dir_row_t'{mk_tick(0, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_STOP, 0, 0, 0, 0, PH_IDLE)});
    dir_rows.push_back(dir_row_t'{mk_tick(10, 400, 100, 100, 1023, CMD_IGNORED, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_STOP, 0, 0, 0, 0, PH_IDLE)});
    dir_rows.push_back(dir_row_t'{mk_tick(20, 400, 100, 100, 1023, MODE_STOP, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_STOP, 0, 0, 0, 1, PH_IDLE)});
    dir_rows.push_back(dir_row_t'{mk_tick(100, 400, 100, 100, 1023, MODE_START, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, 255, 255, 1, 0, PH_FWD)});
    dir_rows.push_back(dir_row_t'{mk_tick(200, 29, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, 255, 255, 0, 0, PH_REV)});
    dir_rows.push_back(dir_row_t'{mk_tick(600, 400, 100, 50, 1023, CMD_NONE, 0, 400, 1500),
                       1'b1, mk_cmd(DRIVE_REV, 255, 255, 0, 0, PH_REV)});
    dir_rows.push_back(dir_row_t'{mk_tick(601, 400, 100, 50, 1023, CMD_NONE, 0, 400, 1500),
                       1'b1, mk_cmd(DRIVE_REV, 255, 255, 0, 0, PH_TURN)});
    dir_rows.push_back(dir_row_t'{mk_tick(1001, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_LEFT, 255, 255, 0, 0, PH_TURN)});
    dir_rows.push_back(dir_row_t'{mk_tick(1002, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, KickLeftDuty, KickRightDuty, 1, 0, PH_FWD)});
    dir_rows.push_back(dir_row_t'{mk_tick(1100, 30, 100, 100, 300, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, 255, 255, 0, 0, PH_FWD)});
    dir_rows.push_back(dir_row_t'{mk_tick(1200, 400, 100, 100, 299, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, 255, 255, 0, 0, PH_REV)});
    dir_rows.push_back(dir_row_t'{mk_tick(1601, 400, 50, 61, 1023, CMD_NONE, 1, 899, 1500),
                       1'b1, mk_cmd(DRIVE_REV, 255, 255, 0, 0, PH_TURN)});
    dir_rows.push_back(dir_row_t'{mk_tick(1700, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_RIGHT, 255, 255, 0, 0, PH_TURN)});
    dir_rows.push_back(dir_row_t'{mk_tick(1800, 400, 100, 100, 1023, MODE_STOP, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_STOP, 0, 0, 0, 1, PH_IDLE)});
    dir_rows.push_back(dir_row_t'{mk_tick(2000, 0, 100, 100, 1023, MODE_START, 0, 600, 1500),
                       1'b1, mk_cmd(DRIVE_FWD, 255, 255, 1, 0, PH_REV)});
    dir_rows.push_back(dir_row_t'{mk_tick(2401, 400, 200, 200, 1023, CMD_NONE, 1, 1023, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(3425, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(3500, 10, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(3901, 400, 300, 20, 1023, CMD_NONE, 0, 600, 2047),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(5000, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(5949, 400, 100, 100, 1023, CMD_NONE, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(11949, 511, 511, 0, 0, CMD_NONE, 0, 0, 0),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(11950, 400, 100, 100, 1023, CMD_IGNORED, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(11960, 400, 100, 100, 1023, MODE_START, 0, 600, 1500),
                       1'b0, '0});
    dir_rows.push_back(dir_row_t'{mk_tick(32'hFFFF_FFFF, 511, 511, 511, 1023, MODE_STOP, 1,
                                          1023, 2047),
                       1'b1, mk_cmd(DRIVE_STOP, 0, 0, 0, 1, PH_IDLE)});
    foreach (dir_rows[i]) send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own settings; the idle pattern changes every two phases.
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      case (p)
        0: setting_vals = '{30, 300, 400, 5000, 10, 255, 255, 255};
        1: setting_vals = '{default: 0};
        2: setting_vals = '{400, 1023, 65535, 65535, 255, 255, 255, 255};
        4: setting_vals = '{60, 500, 150, 3000, 30, 180, 200, 128};
        default: setting_vals = '{16'($urandom_range(200, 10)), 16'($urandom_range(900, 100)),
                                  16'($urandom_range(1500, 50)), 16'($urandom_range(20000, 500)),
                                  16'($urandom_range(60)), 16'($urandom_range(255)),
                                  16'($urandom_range(255)), 16'($urandom_range(255))};
      endcase
      load_settings();
      if (p < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 86;
      end else if (p < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Put the millisecond clock just short of its wrap.
      if (p == 1) sim_ms = 32'hFFFF_FC00;
      for (int n = 0; n < PhaseTicks; n++) begin
        if ($urandom_range(149) == 0) wait_for_results();
        send_tick(random_tick(), 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (30) @(posedge clk);
    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
